// ===== rtl/note_to_frequency_tuned_defines.svh =====
// ============================================================================
// Assertion macros for the tuned note to frequency converter
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ============================================================================
`ifndef NOTE_TO_FREQUENCY_TUNED_DEFINES_SVH
`define NOTE_TO_FREQUENCY_TUNED_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge.
`define NTF_ASSERT_IMPL(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define NTF_ASSERT_NEXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`else

`define NTF_ASSERT_IMPL(name, clock, rst_n, ante, cons)
`define NTF_ASSERT_NEXT(name, clock, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ntf_pkg.sv =====
// ============================================================================
// Tuned note to frequency package
// Widths, register codes and the constant tables shared by the design.
// ============================================================================
package ntf_pkg;

	localparam int NOTES_PER_OCTAVE  = 12;
	localparam int EXP_TABLE_ENTRIES = 256;

	// Field and register widths.
	localparam int NOTE_W      = 7;
	localparam int NOTE_COUNT  = 1 << NOTE_W;
	localparam int FREQ_W      = 32;
	localparam int REF_FREQ_W  = 24;
	localparam int CENTS_W     = 64;
	localparam int OFFSET_W    = 16;
	localparam int CLASS_W     = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [REF_FREQ_W-1:0] REF_FREQ_RESET = 24'd112640;
	localparam logic [NOTE_W-1:0]     REF_NOTE_RESET = 7'd69;

	// Pitch arithmetic in 1/9600 octave units.
	localparam int OCT_UNITS      = 9600;
	localparam int UNITS_PER_NOTE = 800;
	localparam int OCT_BIAS       = 15;
	localparam int U_W            = 19;
	localparam int DIST_W         = U_W + 1;
	localparam int OCT_W          = 5;
	localparam int FRAC_W         = 14;
	localparam int OCT_RECIP      = (1 << U_W) / OCT_UNITS;

	// Table index split of the octave fraction.
	localparam int     IDX_W       = $clog2(EXP_TABLE_ENTRIES);
	localparam int     X_W         = $clog2(OCT_UNITS * EXP_TABLE_ENTRIES);
	localparam longint IDX_RECIP   = (64'd1 << X_W) / OCT_UNITS;
	localparam longint NIDX_RECIP  = EXP_TABLE_ENTRIES * IDX_RECIP;

	// Interpolation: 9600 = 75 * 2^7, so the rounding divide is a shift and a divide by 75.
	localparam int     EXP_W       = 32;
	localparam int     DIFF_W      = 32 - IDX_W;
	localparam int     NUM_W       = DIFF_W + FRAC_W;
	localparam int     ROUND_HALF  = OCT_UNITS / 2;
	localparam int     UNIT_SHIFT  = 7;
	localparam int     UNIT_ODD    = 75;
	localparam int     B_W         = NUM_W - UNIT_SHIFT;
	localparam longint B_RECIP     = (64'd1 << B_W) / UNIT_ODD;

	// Scaling by the reference frequency and the octave shift.
	localparam int P_W        = REF_FREQ_W + EXP_W;
	localparam int PR_W       = P_W + 1;
	localparam int SHIFT_W    = 6;
	localparam int SHIFT_BASE = 22 + OCT_BIAS;

	localparam longint LN2_Q30 = 64'd744261118;
	localparam longint ONE_Q30 = 64'd1073741824;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CENTS_0_3,
		REG_CENTS_4_7,
		REG_CENTS_8_11,
		REG_REF_FREQ,
		REG_REF_NOTE
	} cfg_reg_t;

	typedef logic [EXP_W-1:0]   exp_word_t;
	typedef exp_word_t          exp_tab_t [EXP_TABLE_ENTRIES];
	typedef logic [CLASS_W-1:0] class_t;
	typedef class_t             class_tab_t [NOTE_COUNT];

	// 2^(x / ln 2) by a truncating 25-term Taylor series in Q30.
	function automatic logic [63:0] exp_q30(input logic [63:0] x);
		logic [63:0] t;
		logic [63:0] s;
		t = ONE_Q30;
		s = ONE_Q30;
		t = ((t * x) >> 30) / 64'd1;  s = s + t;
		t = ((t * x) >> 30) / 64'd2;  s = s + t;
		t = ((t * x) >> 30) / 64'd3;  s = s + t;
		t = ((t * x) >> 30) / 64'd4;  s = s + t;
		t = ((t * x) >> 30) / 64'd5;  s = s + t;
		t = ((t * x) >> 30) / 64'd6;  s = s + t;
		t = ((t * x) >> 30) / 64'd7;  s = s + t;
		t = ((t * x) >> 30) / 64'd8;  s = s + t;
		t = ((t * x) >> 30) / 64'd9;  s = s + t;
		t = ((t * x) >> 30) / 64'd10; s = s + t;
		t = ((t * x) >> 30) / 64'd11; s = s + t;
		t = ((t * x) >> 30) / 64'd12; s = s + t;
		t = ((t * x) >> 30) / 64'd13; s = s + t;
		t = ((t * x) >> 30) / 64'd14; s = s + t;
		t = ((t * x) >> 30) / 64'd15; s = s + t;
		t = ((t * x) >> 30) / 64'd16; s = s + t;
		t = ((t * x) >> 30) / 64'd17; s = s + t;
		t = ((t * x) >> 30) / 64'd18; s = s + t;
		t = ((t * x) >> 30) / 64'd19; s = s + t;
		t = ((t * x) >> 30) / 64'd20; s = s + t;
		t = ((t * x) >> 30) / 64'd21; s = s + t;
		t = ((t * x) >> 30) / 64'd22; s = s + t;
		t = ((t * x) >> 30) / 64'd23; s = s + t;
		t = ((t * x) >> 30) / 64'd24; s = s + t;
		return s;
	endfunction

	// Table of 2^(i/N) in Q2.30, starting at point i = first.
	function automatic exp_tab_t build_exp_tab(input int unsigned first);
		exp_tab_t    tab;
		logic [63:0] pt;
		logic [63:0] x;
		for (int unsigned i = 0; i < EXP_TABLE_ENTRIES; i++) begin
			pt     = 64'(i + first);
			x      = (pt * LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / EXP_TABLE_ENTRIES;
			tab[i] = EXP_W'(exp_q30(x));
		end
		return tab;
	endfunction

	function automatic class_tab_t build_class_tab();
		class_tab_t tab;
		for (int i = 0; i < NOTE_COUNT; i++) begin
			tab[i] = CLASS_W'(i % NOTES_PER_OCTAVE);
		end
		return tab;
	endfunction

	localparam exp_tab_t   EXP_LO    = build_exp_tab(0);
	localparam exp_tab_t   EXP_HI    = build_exp_tab(1);
	localparam class_tab_t CLASS_TAB = build_class_tab();

endpackage

// ===== rtl/ntf_if.sv =====
// ============================================================================
// Tuned note to frequency channels
// Valid/ready channels for notes, frequencies and register writes.
// ============================================================================
interface ntf_note_if import ntf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NOTE_W-1:0] note_number;

	modport source (output valid, output note_number, input ready);
	modport sink (input valid, input note_number, output ready);
endinterface

interface ntf_freq_if import ntf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency;
	logic              saturated;

	modport source (output valid, output frequency, output saturated, input ready);
	modport sink (input valid, input frequency, input saturated, output ready);
endinterface

interface ntf_cfg_if import ntf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/note_to_frequency_tuned.sv =====
// An accepted note request passes stages 1 to 12 in order; its result is offered from stage 12.
// Throughput: one request per cycle; the twelve stages each hold their own valid bit
// and stall individually, so bubbles close up behind a blocked output.
// Register writes take effect on the next clock edge; the channel is always ready.
// Reset empties the pipeline and loads the defaults: 440 Hz at note 69, no tuning.
// ============================================================================
// Tuned note to frequency converter
// Converts a note number into a Q16.16 frequency using a per pitch class tuning
// table, a reference note and a reference frequency.
// ============================================================================
`include "note_to_frequency_tuned_defines.svh"

module note_to_frequency_tuned import ntf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	ntf_note_if.sink       notes,
	ntf_freq_if.source     freqs,
	ntf_cfg_if.sink        cfg
);

	localparam int NS = 12;

	// ------------------------------------------------------------------------
	// Configuration registers. Writes are taken every cycle; an index beyond
	// the register list is dropped.
	// ------------------------------------------------------------------------
	logic [CENTS_W-1:0]    cents_q [3];
	logic [REF_FREQ_W-1:0] ref_freq_q;
	logic [NOTE_W-1:0]     ref_note_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cents_q[0] <= '0;
			cents_q[1] <= '0;
			cents_q[2] <= '0;
			ref_freq_q <= REF_FREQ_RESET;
			ref_note_q <= REF_NOTE_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_CENTS_0_3:  cents_q[0] <= cfg.data;
				REG_CENTS_4_7:  cents_q[1] <= cfg.data;
				REG_CENTS_8_11: cents_q[2] <= cfg.data;
				REG_REF_FREQ:   ref_freq_q <= cfg.data[REF_FREQ_W-1:0];
				REG_REF_NOTE:   ref_note_q <= cfg.data[NOTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Flow control. Each stage loads when it is empty or when the stage after
	// it is loading, so a stall downstream of a gap never holds back the input.
	// ------------------------------------------------------------------------
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = freqs.ready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign notes.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= notes.valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: pitch class offset and distance from the reference note, in
	// 1/9600 octave units. The distance is biased by fifteen octaves so that
	// the following divide works on a non-negative value.
	// ------------------------------------------------------------------------
	class_t                    pclass;
	logic [CENTS_W-1:0]        cents_word;
	logic signed [OFFSET_W-1:0] offset;
	logic signed [NOTE_W:0]    note_diff;
	logic signed [DIST_W-1:0]  pitch_dist;
	logic [U_W-1:0]            u_s1;

	always_comb begin
		pclass     = CLASS_TAB[notes.note_number];
		cents_word = cents_q[pclass[CLASS_W-1:2]];
		offset     = signed'(cents_word[{pclass[1:0], 4'b0000} +: OFFSET_W]);
		note_diff  = signed'({1'b0, notes.note_number}) - signed'({1'b0, ref_note_q});
		pitch_dist = DIST_W'(note_diff) * DIST_W'(UNITS_PER_NOTE) + DIST_W'(offset)
		             + DIST_W'(OCT_BIAS * OCT_UNITS);
	end

	// ------------------------------------------------------------------------
	// Stages 2 and 3: whole octaves and fraction. The quotient estimate from
	// the reciprocal is exact or one short, which the remainder check fixes.
	// ------------------------------------------------------------------------
	logic [2*U_W-1:0]  oct_prod;
	logic [U_W-1:0]    u_s2;
	logic [OCT_W-1:0]  oq_s2;
	logic [U_W-1:0]    oct_rem;
	logic [OCT_W-1:0]  oct_s3;
	logic [FRAC_W-1:0] frac_s3;

	always_comb begin
		oct_prod = (2*U_W)'(u_s1) * (2*U_W)'(OCT_RECIP);
		oct_rem  = u_s2 - U_W'(oq_s2) * U_W'(OCT_UNITS);
	end

	// ------------------------------------------------------------------------
	// Stages 4 and 5: table index and interpolation weight from the fraction
	// scaled by the table size, divided by 9600 the same way.
	// ------------------------------------------------------------------------
	logic [FRAC_W+X_W-1:0] idx_prod;
	logic [X_W-1:0]        x_s4;
	logic [IDX_W-1:0]      iq_s4;
	logic [OCT_W-1:0]      oct_s4;
	logic [X_W-1:0]        idx_rem;
	logic [IDX_W-1:0]      idx_s5;
	logic [FRAC_W-1:0]     r_s5;
	logic [OCT_W-1:0]      oct_s5;

	always_comb begin
		idx_prod = (FRAC_W+X_W)'(frac_s3) * (FRAC_W+X_W)'(NIDX_RECIP);
		idx_rem  = x_s4 - X_W'(iq_s4) * X_W'(OCT_UNITS);
	end

	// ------------------------------------------------------------------------
	// Stages 6 to 9: table lookup and linear interpolation, rounded half up.
	// The weighted step is divided by 9600 as a shift by seven followed by a
	// reciprocal divide by 75 with one correction.
	// ------------------------------------------------------------------------
	logic [EXP_W-1:0]  lo_s6;
	logic [DIFF_W-1:0] diff_s6;
	logic [FRAC_W-1:0] r_s6;
	logic [OCT_W-1:0]  oct_s6;
	logic [NUM_W-1:0]  num_s7;
	logic [EXP_W-1:0]  lo_s7;
	logic [OCT_W-1:0]  oct_s7;
	logic [B_W-1:0]    b_val;
	logic [2*B_W-1:0]  b_prod;
	logic [B_W-1:0]    b_s8;
	logic [DIFF_W-1:0] bq_s8;
	logic [EXP_W-1:0]  lo_s8;
	logic [OCT_W-1:0]  oct_s8;
	logic [B_W-1:0]    b_rem;
	logic [DIFF_W-1:0] step;
	logic [EXP_W-1:0]  m_s9;
	logic [OCT_W-1:0]  oct_s9;

	always_comb begin
		b_val  = B_W'(num_s7 >> UNIT_SHIFT);
		b_prod = (2*B_W)'(b_val) * (2*B_W)'(B_RECIP);
		b_rem  = b_s8 - B_W'(bq_s8) * B_W'(UNIT_ODD);
		step   = (b_rem >= B_W'(UNIT_ODD)) ? bq_s8 + DIFF_W'(1) : bq_s8;
	end

	// ------------------------------------------------------------------------
	// Stages 10 to 12: scale by the reference frequency, add the rounding bit
	// for the octave shift, then shift and clamp to 32 bits.
	// ------------------------------------------------------------------------
	logic [P_W-1:0]     p_s10;
	logic [OCT_W-1:0]   oct_s10;
	logic [SHIFT_W-1:0] shift_amt;
	logic [PR_W-1:0]    pr_s11;
	logic [SHIFT_W-1:0] shift_s11;
	logic [PR_W-1:0]    scaled;
	logic               sat;
	logic [FREQ_W-1:0]  frequency_s12;
	logic               saturated_s12;

	always_comb begin
		shift_amt = SHIFT_W'(SHIFT_BASE) - SHIFT_W'(oct_s10);
		scaled    = pr_s11 >> shift_s11;
		sat       = |scaled[PR_W-1:FREQ_W];
	end

	// Pipeline payload; loaded only when the stage's enable is high.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			u_s1 <= U_W'(pitch_dist);
		end
		if (en[2]) begin
			u_s2  <= u_s1;
			oq_s2 <= OCT_W'(oct_prod >> U_W);
		end
		if (en[3]) begin
			if (oct_rem >= U_W'(OCT_UNITS)) begin
				frac_s3 <= FRAC_W'(oct_rem - U_W'(OCT_UNITS));
				oct_s3  <= oq_s2 + OCT_W'(1);
			end else begin
				frac_s3 <= FRAC_W'(oct_rem);
				oct_s3  <= oq_s2;
			end
		end
		if (en[4]) begin
			x_s4   <= X_W'(frac_s3) * X_W'(EXP_TABLE_ENTRIES);
			iq_s4  <= IDX_W'(idx_prod >> X_W);
			oct_s4 <= oct_s3;
		end
		if (en[5]) begin
			if (idx_rem >= X_W'(OCT_UNITS)) begin
				idx_s5 <= iq_s4 + IDX_W'(1);
				r_s5   <= FRAC_W'(idx_rem - X_W'(OCT_UNITS));
			end else begin
				idx_s5 <= iq_s4;
				r_s5   <= FRAC_W'(idx_rem);
			end
			oct_s5 <= oct_s4;
		end
		if (en[6]) begin
			lo_s6   <= EXP_LO[idx_s5];
			diff_s6 <= DIFF_W'(EXP_HI[idx_s5] - EXP_LO[idx_s5]);
			r_s6    <= r_s5;
			oct_s6  <= oct_s5;
		end
		if (en[7]) begin
			num_s7 <= NUM_W'(diff_s6) * NUM_W'(r_s6) + NUM_W'(ROUND_HALF);
			lo_s7  <= lo_s6;
			oct_s7 <= oct_s6;
		end
		if (en[8]) begin
			b_s8   <= b_val;
			bq_s8  <= DIFF_W'(b_prod >> B_W);
			lo_s8  <= lo_s7;
			oct_s8 <= oct_s7;
		end
		if (en[9]) begin
			m_s9   <= lo_s8 + EXP_W'(step);
			oct_s9 <= oct_s8;
		end
		if (en[10]) begin
			p_s10   <= P_W'(ref_freq_q) * P_W'(m_s9);
			oct_s10 <= oct_s9;
		end
		if (en[11]) begin
			pr_s11    <= PR_W'(p_s10) + (PR_W'(1) << (shift_amt - SHIFT_W'(1)));
			shift_s11 <= shift_amt;
		end
		if (en[12]) begin
			frequency_s12 <= sat ? '1 : scaled[FREQ_W-1:0];
			saturated_s12 <= sat;
		end
	end

	assign freqs.valid     = vld_q[NS];
	assign freqs.frequency = frequency_s12;
	assign freqs.saturated = saturated_s12;

	// ------------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------------
	// An accepted note always occupies the first stage on the next cycle.
	`NTF_ASSERT_NEXT(a_accept_fills, clk, arst_n, notes.valid && notes.ready, vld_q[1])
	// With every stage full and the output blocked, no note may be taken.
	`NTF_ASSERT_IMPL(a_full_blocks, clk, arst_n, (&vld_q) && !freqs.ready, !notes.ready)
	// The octave split leaves a fraction below one octave.
	`NTF_ASSERT_IMPL(a_frac_range, clk, arst_n, vld_q[3], frac_s3 < FRAC_W'(OCT_UNITS))
	// A clamped result carries the largest code.
	`NTF_ASSERT_IMPL(a_sat_clamps, clk, arst_n, freqs.valid && freqs.saturated, &freqs.frequency)

endmodule
